@@ rtl/pbwt_pkg.sv @@
// Shared constants, state encoding and control bundles for the PBWT update block.
`default_nettype none

package pbwt_pkg;

  localparam int unsigned MAX_HAP  = 64;
  localparam int unsigned COL_BITS = 16;
  localparam int unsigned IDX_W    = $clog2(MAX_HAP);
  localparam int unsigned CNT_W    = $clog2(MAX_HAP + 1);
  localparam int unsigned CFG_W    = 7;

  localparam logic [COL_BITS-1:0] COL_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_EMIT
  } pbwt_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic walk_en;
    logic emit_en;
  } pbwt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_done;
    logic emit_done;
  } pbwt_sts_t;

endpackage

`default_nettype wire

@@ rtl/pbwt_ctrl.sv @@
// Sequencer: idle, walk of the current order, emission of the new order.
`default_nettype none

module pbwt_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_valid_i,
  output logic                    s_ready_o,
  input  wire pbwt_pkg::pbwt_sts_t sts_i,
  output pbwt_pkg::pbwt_cmd_t     cmd_o
);
  import pbwt_pkg::*;

  pbwt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    s_ready_o     = 1'b0;
    cmd_o.load    = 1'b0;
    cmd_o.walk_en = 1'b0;
    cmd_o.emit_en = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o  = 1'b1;
        cmd_o.load = s_valid_i;
        if (s_valid_i) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd_o.walk_en = 1'b1;
        if (sts_i.walk_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd_o.emit_en = 1'b1;
        if (sts_i.emit_done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/pbwt_datapath.sv @@
// Order and divergence stores, partition walk, scratch buffer and output register.
`default_nettype none

module pbwt_datapath (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire pbwt_pkg::pbwt_cmd_t          cmd_i,
  output pbwt_pkg::pbwt_sts_t               sts_o,
  input  wire logic [63:0]                  column_i,
  input  wire logic                         start_i,
  input  wire logic [pbwt_pkg::CNT_W-1:0]   count_i,
  output logic                              m_valid_o,
  input  wire logic                         m_ready_i,
  output logic [5:0]                        rank_o,
  output logic [5:0]                        hap_id_o,
  output logic [15:0]                       div_o,
  output logic                              last_o
);
  import pbwt_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]    id;
    logic [COL_BITS-1:0] div;
  } entry_t;

  // stores
  entry_t             pfx_mem [MAX_HAP];
  entry_t             scr_mem [MAX_HAP];
  logic [MAX_HAP-1:0] pfx_vld_q;

  // per-column registers
  logic [MAX_HAP-1:0]  col_q;
  logic [CNT_W-1:0]    n_q;
  logic [COL_BITS-1:0] colcnt_q;
  logic [COL_BITS-1:0] p_q, q_q, p_d, q_d;
  logic [CNT_W-1:0]    zi_q, oi_q, zi_d, oi_d;

  // walk pipeline
  logic [CNT_W-1:0] ridx_q;
  logic             rd_issue;
  logic             rvld_q;
  entry_t           pfx_rd_q;
  logic             pfx_rd_vld_q;
  logic [IDX_W-1:0] pfx_raddr_q;

  logic [IDX_W-1:0]    cur_id;
  logic [COL_BITS-1:0] cur_div, pm, qm;
  logic                scr_we;
  logic [IDX_W-1:0]    scr_waddr;

  // emit pipeline
  logic [CNT_W-1:0] eidx_q, ones_off;
  logic [IDX_W-1:0] scr_raddr;
  logic             ren, pend_q, out_ready, xfer;
  entry_t           scr_rd_q;
  logic [IDX_W-1:0] prank_q;

  logic [COL_BITS-1:0] col_base, seed;

  // seed and column advance at load
  always_comb begin
    col_base = start_i ? '0 : colcnt_q;
    seed     = (col_base < COL_MAX) ? col_base + 1'b1 : COL_MAX;
  end

  // walk: read prefix entry, partition into zeros from the bottom, ones from the top
  assign rd_issue = cmd_i.walk_en && (ridx_q < n_q);

  always_comb begin
    cur_id    = pfx_rd_vld_q ? pfx_rd_q.id  : pfx_raddr_q;
    cur_div   = pfx_rd_vld_q ? pfx_rd_q.div : '0;
    pm        = (cur_div > p_q) ? cur_div : p_q;
    qm        = (cur_div > q_q) ? cur_div : q_q;
    p_d       = p_q;
    q_d       = q_q;
    zi_d      = zi_q;
    oi_d      = oi_q;
    scr_we    = 1'b0;
    scr_waddr = zi_q[IDX_W-1:0];
    if (rvld_q) begin
      scr_we = 1'b1;
      if (!col_q[cur_id]) begin
        scr_waddr = zi_q[IDX_W-1:0];
        zi_d      = zi_q + 1'b1;
        p_d       = '0;
        q_d       = qm;
      end else begin
        scr_waddr = IDX_W'(MAX_HAP - 1) - oi_q[IDX_W-1:0];
        oi_d      = oi_q + 1'b1;
        p_d       = pm;
        q_d       = '0;
      end
    end
  end

  assign sts_o.walk_done = rvld_q && ((zi_q + oi_q + 1'b1) == n_q);

  // emit: read scratch in rank order, ones are stored reversed
  assign ones_off  = eidx_q - zi_q;
  assign scr_raddr = (eidx_q < zi_q) ? eidx_q[IDX_W-1:0]
                                     : IDX_W'(MAX_HAP - 1) - ones_off[IDX_W-1:0];
  assign out_ready = !m_valid_o || m_ready_i;
  assign xfer      = pend_q && out_ready;
  assign ren       = cmd_i.emit_en && (eidx_q < n_q) && (!pend_q || out_ready);

  assign sts_o.emit_done = (eidx_q == n_q) && !pend_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colcnt_q  <= '0;
      ridx_q    <= '0;
      rvld_q    <= 1'b0;
      zi_q      <= '0;
      oi_q      <= '0;
      eidx_q    <= '0;
      pend_q    <= 1'b0;
      m_valid_o <= 1'b0;
      n_q       <= CNT_W'(MAX_HAP);
      pfx_vld_q <= '0;
    end else begin
      if (cmd_i.load) begin
        n_q      <= count_i;
        colcnt_q <= (col_base < COL_MAX) ? col_base + 1'b1 : COL_MAX;
        ridx_q   <= '0;
        zi_q     <= '0;
        oi_q     <= '0;
        eidx_q   <= '0;
      end else begin
        zi_q <= zi_d;
        oi_q <= oi_d;
        if (rd_issue) begin
          ridx_q <= ridx_q + 1'b1;
        end
        if (ren) begin
          eidx_q <= eidx_q + 1'b1;
        end
      end
      rvld_q <= rd_issue;
      if (ren) begin
        pend_q <= 1'b1;
      end else if (xfer) begin
        pend_q <= 1'b0;
      end
      if (xfer) begin
        m_valid_o <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_o <= 1'b0;
      end
      // drop the whole order back to identity on a panel start
      if (cmd_i.load && start_i) begin
        pfx_vld_q <= '0;
      end else if (xfer) begin
        pfx_vld_q[prank_q] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      col_q <= column_i[MAX_HAP-1:0];
      p_q   <= seed;
      q_q   <= seed;
    end else begin
      p_q <= p_d;
      q_q <= q_d;
    end
    if (rd_issue) begin
      pfx_rd_q     <= pfx_mem[ridx_q[IDX_W-1:0]];
      pfx_rd_vld_q <= pfx_vld_q[ridx_q[IDX_W-1:0]];
      pfx_raddr_q  <= ridx_q[IDX_W-1:0];
    end
    if (scr_we) begin
      scr_mem[scr_waddr] <= '{id: cur_id, div: (!col_q[cur_id]) ? pm : qm};
    end
    if (ren) begin
      scr_rd_q <= scr_mem[scr_raddr];
      prank_q  <= eidx_q[IDX_W-1:0];
    end
    if (xfer) begin
      pfx_mem[prank_q] <= scr_rd_q;
      rank_o           <= 6'(prank_q);
      hap_id_o         <= 6'(scr_rd_q.id);
      div_o            <= 16'(scr_rd_q.div);
      last_o           <= ((CNT_W'(prank_q) + 1'b1) == n_q);
    end
  end

endmodule

`default_nettype wire

@@ rtl/pbwt_prefix_divergence_update.sv @@
// Top level: configuration register, stream ports, controller and datapath.
`default_nettype none

// Positional BWT prefix order and divergence update. Each slave transaction
// carries one panel column (bit h is the allele of haplotype h) and, in tuser,
// a panel start flag that first restores identity order, zero divergence and
// column 0. The block walks the stored order, one rank per cycle through the
// prefix store's single read port, partitioning into allele 0 then allele 1,
// and then emits one master transaction per rank, one per cycle while the output
// does not stall, through the scratch buffer's read port, with tlast on the
// final rank. A column is accepted, then walked behind the registered store
// read, then its ranks are emitted and the read register is drained; output
// stalls lengthen the emission. No new column is accepted until the previous
// one has been handed to the output register. haplotype_count (cfg_wdata_i)
// is clamped to 1..64 and is to be written by the user only while the block
// is idle; the block itself does not enforce this.

module pbwt_prefix_divergence_update (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [6:0]  cfg_wdata_i,     // haplotype_count
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [63:0] s_axis_tdata_i,  // [63:0] column_alleles
  input  wire logic        s_axis_tuser_i,  // start_panel
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,  // [5:0] rank, [11:6] haplotype_id,
                                            // [27:12] divergence, [31:28] zero
  output logic             m_axis_tlast_o   // last
);
  import pbwt_pkg::*;

  logic [CFG_W-1:0] hap_count_q;
  logic [CNT_W-1:0] count_eff;
  pbwt_cmd_t        cmd;
  pbwt_sts_t        sts;
  logic [5:0]       rank, hap_id;
  logic [15:0]      div;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hap_count_q <= CFG_W'(64);
    end else if (cfg_we_i) begin
      hap_count_q <= cfg_wdata_i;
    end
  end

  // clamp the count into the supported range
  always_comb begin
    if (hap_count_q == '0) begin
      count_eff = CNT_W'(1);
    end else if (hap_count_q > CFG_W'(MAX_HAP)) begin
      count_eff = CNT_W'(MAX_HAP);
    end else begin
      count_eff = CNT_W'(hap_count_q);
    end
  end

  pbwt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  pbwt_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .column_i  (s_axis_tdata_i),
    .start_i   (s_axis_tuser_i),
    .count_i   (count_eff),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .rank_o    (rank),
    .hap_id_o  (hap_id),
    .div_o     (div),
    .last_o    (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {4'b0000, div, hap_id, rank};

endmodule

`default_nettype wire
